>>> rtl/core/ptts_pkg.sv
// ----------------------------------------------------------------------------
// ptts_pkg
// Shared types, constants and the control store of the tick scheduler.
// ----------------------------------------------------------------------------
package ptts_pkg;

  localparam int MAX_RESULTS = 8;
  localparam int CNT_W       = 4;
  localparam int DLY_W       = 16;
  localparam int TASK_W      = 3;
  localparam int SLOT_W      = 8;
  localparam int IN_DATA_W   = 48;
  localparam int OUT_DATA_W  = 8;

  typedef enum logic [1:0] {
    KIND_CREATE = 2'd0,
    KIND_DUE    = 2'd1,
    KIND_IDLE   = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    STEP_FETCH  = 3'd0,
    STEP_PRIME  = 3'd1,
    STEP_EVAL   = 3'd2,
    STEP_CREATE = 3'd3,
    STEP_FINAL  = 3'd4
  } step_t;

  typedef enum logic [1:0] {
    JMP_ALWAYS  = 2'd0,
    JMP_FETCH   = 2'd1,
    JMP_OUTFREE = 2'd2,
    JMP_EVAL    = 2'd3
  } jump_t;

  typedef struct packed {
    logic  accept;
    logic  eval;
    logic  emit_create;
    logic  emit_final;
    jump_t jump;
    step_t target;
  } ctrl_t;

  typedef struct packed {
    logic in_hs;
    logic is_create;
    logic stall;
    logic last_slot;
    logic out_free;
  } dp_status_t;

  // control store: one word per step
  function automatic ctrl_t ucode(step_t s);
    ctrl_t w;
    w = '{accept: 1'b1, eval: 1'b0, emit_create: 1'b0, emit_final: 1'b0,
          jump: JMP_FETCH, target: STEP_CREATE};
    case (s)
      STEP_FETCH: begin
        w = '{accept: 1'b1, eval: 1'b0, emit_create: 1'b0, emit_final: 1'b0,
              jump: JMP_FETCH, target: STEP_CREATE};
      end
      STEP_PRIME: begin
        w = '{accept: 1'b0, eval: 1'b0, emit_create: 1'b0, emit_final: 1'b0,
              jump: JMP_ALWAYS, target: STEP_EVAL};
      end
      STEP_EVAL: begin
        w = '{accept: 1'b0, eval: 1'b1, emit_create: 1'b0, emit_final: 1'b0,
              jump: JMP_EVAL, target: STEP_FINAL};
      end
      STEP_CREATE: begin
        w = '{accept: 1'b0, eval: 1'b0, emit_create: 1'b1, emit_final: 1'b0,
              jump: JMP_OUTFREE, target: STEP_FETCH};
      end
      STEP_FINAL: begin
        w = '{accept: 1'b0, eval: 1'b0, emit_create: 1'b0, emit_final: 1'b1,
              jump: JMP_OUTFREE, target: STEP_FETCH};
      end
      default: begin
        w = '{accept: 1'b0, eval: 1'b0, emit_create: 1'b0, emit_final: 1'b0,
              jump: JMP_ALWAYS, target: STEP_FETCH};
      end
    endcase
    return w;
  endfunction

endpackage

>>> rtl/core/ptts_seq.sv
// ----------------------------------------------------------------------------
// ptts_seq
// Step counter and control store lookup with conditional jumps.
// ----------------------------------------------------------------------------
module ptts_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  ptts_pkg::dp_status_t sts,
  output ptts_pkg::ctrl_t     ctrl
);
  import ptts_pkg::*;

  step_t step_r;
  step_t step_nxt;

  assign ctrl = ucode(step_r);

  always_comb begin
    step_nxt = step_r;
    case (ctrl.jump)
      JMP_ALWAYS: begin
        step_nxt = ctrl.target;
      end
      JMP_FETCH: begin
        if (sts.in_hs) begin
          step_nxt = sts.is_create ? ctrl.target : step_t'(3'(step_r) + 3'd1);
        end
      end
      JMP_OUTFREE: begin
        if (sts.out_free) begin
          step_nxt = ctrl.target;
        end
      end
      JMP_EVAL: begin
        if (!sts.stall && sts.last_slot) begin
          step_nxt = ctrl.target;
        end
      end
      default: begin
        step_nxt = STEP_FETCH;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= STEP_FETCH;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

>>> rtl/core/ptts_dp.sv
// ----------------------------------------------------------------------------
// ptts_dp
// Slot table, slot walker and result register driven by the control word.
// ----------------------------------------------------------------------------
module ptts_dp #(
  parameter int TASK_SLOTS = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ptts_pkg::ctrl_t               ctrl,
  output ptts_pkg::dp_status_t          sts,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [ptts_pkg::IN_DATA_W-1:0] in_tdata,
  input  logic                          in_tuser,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [ptts_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic [1:0]                    out_tuser,
  output logic                          out_tlast
);
  import ptts_pkg::*;

  localparam int IDX_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int ENT_W = 2 * DLY_W;

  // {reload period, remaining delay}
  logic [ENT_W-1:0]  mem [TASK_SLOTS];
  logic [ENT_W-1:0]  rd_q;
  logic [IDX_W-1:0]  rd_addr;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  logic [ENT_W-1:0]  wr_data;

  logic [TASK_SLOTS-1:0] active_r, active_nxt;

  logic [SLOT_W-1:0] slot_r;
  logic [DLY_W-1:0]  period_r;
  logic [DLY_W-1:0]  first_r;
  logic              handler_r;

  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              pend_v_r, pend_v_nxt;
  logic [IDX_W-1:0]  pend_r, pend_nxt;

  logic              out_valid_r, out_valid_nxt;
  kind_t             out_kind_r, out_kind_nxt;
  logic              out_status_r, out_status_nxt;
  logic [TASK_W-1:0] out_task_r, out_task_nxt;
  logic              out_last_r, out_last_nxt;

  logic              in_hs;
  logic              out_free;
  logic              last_slot;
  logic              slot_act;
  logic [DLY_W-1:0]  cur_dly;
  logic [DLY_W-1:0]  cur_per;
  logic              due;
  logic              report;
  logic              stall;
  logic              advance;
  logic              create_ok;
  logic [DLY_W-1:0]  new_dly;
  logic [IDX_W+TASK_W-1:0] pend_ext;

  assign in_tready = ctrl.accept;
  assign in_hs     = in_tvalid & ctrl.accept;
  assign out_free  = !out_valid_r || out_tready;
  assign last_slot = (idx_r == IDX_W'(TASK_SLOTS - 1));

  assign slot_act  = active_r[idx_r];
  assign cur_dly   = rd_q[DLY_W-1:0];
  assign cur_per   = rd_q[ENT_W-1:DLY_W];
  assign due       = ctrl.eval && slot_act && (cur_dly == '0);
  assign report    = due && (cnt_r < CNT_W'(MAX_RESULTS));
  // a second reported slot pushes the held one out
  assign stall     = report && pend_v_r && !out_free;
  assign advance   = ctrl.eval && !stall;
  assign new_dly   = due ? (cur_per - DLY_W'(1)) : (cur_dly - DLY_W'(1));
  assign create_ok = (slot_r < SLOT_W'(TASK_SLOTS)) && handler_r;
  assign pend_ext  = {{TASK_W{1'b0}}, pend_r};

  assign sts = '{in_hs: in_hs, is_create: in_tuser, stall: stall,
                 last_slot: last_slot, out_free: out_free};

  always_comb begin
    rd_addr = idx_r;
    if (advance && !last_slot) begin
      rd_addr = idx_r + IDX_W'(1);
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx_r;
    wr_data = {cur_per, new_dly};
    active_nxt = active_r;
    if (ctrl.emit_create && out_free && create_ok) begin
      wr_en   = 1'b1;
      wr_addr = slot_r[IDX_W-1:0];
      wr_data = {period_r, first_r};
      active_nxt[slot_r[IDX_W-1:0]] = 1'b1;
    end else if (advance && slot_act) begin
      wr_en = 1'b1;
    end
  end

  always_comb begin
    idx_nxt        = idx_r;
    cnt_nxt        = cnt_r;
    pend_v_nxt     = pend_v_r;
    pend_nxt       = pend_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_kind_nxt   = out_kind_r;
    out_status_nxt = out_status_r;
    out_task_nxt   = out_task_r;
    out_last_nxt   = out_last_r;
    if (in_hs) begin
      idx_nxt    = '0;
      cnt_nxt    = '0;
      pend_v_nxt = 1'b0;
    end
    if (advance) begin
      if (!last_slot) begin
        idx_nxt = idx_r + IDX_W'(1);
      end
      if (report) begin
        if (pend_v_r) begin
          out_valid_nxt  = 1'b1;
          out_kind_nxt   = KIND_DUE;
          out_status_nxt = 1'b0;
          out_task_nxt   = pend_ext[TASK_W-1:0];
          out_last_nxt   = 1'b0;
        end
        pend_v_nxt = 1'b1;
        pend_nxt   = idx_r;
        cnt_nxt    = cnt_r + CNT_W'(1);
      end
    end
    if (ctrl.emit_create && out_free) begin
      out_valid_nxt  = 1'b1;
      out_kind_nxt   = KIND_CREATE;
      out_status_nxt = !create_ok;
      out_task_nxt   = '0;
      out_last_nxt   = 1'b1;
    end
    if (ctrl.emit_final && out_free) begin
      out_valid_nxt  = 1'b1;
      out_kind_nxt   = pend_v_r ? KIND_DUE : KIND_IDLE;
      out_status_nxt = 1'b0;
      out_task_nxt   = pend_v_r ? pend_ext[TASK_W-1:0] : '0;
      out_last_nxt   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= '0;
      out_valid_r <= 1'b0;
      pend_v_r    <= 1'b0;
      idx_r       <= '0;
      cnt_r       <= '0;
    end else begin
      active_r    <= active_nxt;
      out_valid_r <= out_valid_nxt;
      pend_v_r    <= pend_v_nxt;
      idx_r       <= idx_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_hs) begin
      slot_r    <= in_tdata[7:0];
      period_r  <= in_tdata[23:8];
      first_r   <= in_tdata[39:24];
      handler_r <= in_tdata[40];
    end
    pend_r       <= pend_nxt;
    out_kind_r   <= out_kind_nxt;
    out_status_r <= out_status_nxt;
    out_task_r   <= out_task_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W - TASK_W - 1){1'b0}}, out_task_r, out_status_r};
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

endmodule

>>> rtl/core/periodic_task_tick_scheduler_core.sv
// ----------------------------------------------------------------------------
// periodic_task_tick_scheduler_core
// Time-triggered cooperative scheduler: per-slot countdown timers, walked
// slot by slot under a small control store.
// ----------------------------------------------------------------------------
//  channel | dir | payload
//  --------+-----+---------------------------------------------------------
//  in_     | in  | tuser: cmd; tdata: slot, period, first_delay, has_handler
//  out_    | out | tuser: kind; tdata: status, task_res; tlast: last
//
//  a create beat runs fetch, then table write with answer
//  a tick beat runs fetch, table read prime, a walk over the slots in turn
//  through one table read port and one table write port, final result
//  a held result register stalls the walk only when another due slot appears
//  reset clears the active bits at once; no clearing pass over the table
// ----------------------------------------------------------------------------
module periodic_task_tick_scheduler_core #(
  parameter int TASK_SLOTS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [7:0] slot, [23:8] period, [39:24] first_delay, [40] has_handler
  input  logic [47:0] in_tdata,
  // [0] cmd
  input  logic        in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [0] status, [3:1] task_res
  output logic [7:0]  out_tdata,
  // [1:0] kind
  output logic [1:0]  out_tuser,
  output logic        out_tlast
);
  import ptts_pkg::*;

  ctrl_t      ctrl;
  dp_status_t sts;

  ptts_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .ctrl  (ctrl)
  );

  ptts_dp #(
    .TASK_SLOTS (TASK_SLOTS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (ctrl),
    .sts        (sts),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  a_create_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == KIND_CREATE) |-> out_tlast)
    else $error("create answer without last");

  a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser != KIND_CREATE) |-> !out_tdata[0])
    else $error("status set on a tick result");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.eval && sts.stall) |=> ctrl.eval)
    else $error("slot walk left while stalled");

endmodule

>>> test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stream-level check of the tick scheduler core: commands go in as bursts
// with random gaps, result beats are taken under a shifting stall pattern,
// and each beat is compared with a slot-table model kept inside the bench.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import ptts_pkg::*;

  localparam int  NUM_SLOTS    = 8;
  localparam int  RANDOM_ITEMS = 220;
  localparam int  DRAIN_CYCLES = 30;
  localparam bit  CMD_TICK     = 1'b0;
  localparam bit  CMD_CREATE   = 1'b1;

  typedef struct {
    bit        cmd;
    bit [7:0]  slot;
    bit [15:0] period;
    bit [15:0] first_delay;
    bit        has_handler;
  } sched_cmd_t;

  typedef struct {
    kind_t    kind;
    bit       status;
    bit [2:0] due_slot;
    bit       is_last;
  } sched_result_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata   = '0;
  logic        in_tuser   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;

  sched_cmd_t    pending_cmds[$];
  sched_result_t expected_results[$];
  sched_cmd_t    cmd_on_bus;
  int            error_count = 0;

  // slot table mirror
  bit [15:0] countdown [NUM_SLOTS];
  bit [15:0] period_tab[NUM_SLOTS];
  bit        slot_live [NUM_SLOTS];

  int burst_left = 0;
  int gap_left   = 0;
  int rx_mode    = 0;
  int rx_left    = 0;

  periodic_task_tick_scheduler_core #(.TASK_SLOTS(NUM_SLOTS)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always #6 clk = ~clk;

  function automatic sched_result_t make_result(kind_t k, bit st, bit [2:0] s, bit lst);
    sched_result_t r;
    r.kind     = k;
    r.status   = st;
    r.due_slot = s;
    r.is_last  = lst;
    return r;
  endfunction

  // advance the slot table by one beat and queue the result beats it causes
  function automatic void schedule_step(sched_cmd_t c);
    int n_due;
    n_due = 0;
    if (c.cmd == CMD_CREATE) begin
      if (c.slot < NUM_SLOTS && c.has_handler) begin
        countdown[c.slot]  = c.first_delay;
        period_tab[c.slot] = c.period;
        slot_live[c.slot]  = 1'b1;
        expected_results.push_back(make_result(KIND_CREATE, 1'b0, 3'd0, 1'b1));
      end else begin
        expected_results.push_back(make_result(KIND_CREATE, 1'b1, 3'd0, 1'b1));
      end
      return;
    end
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (slot_live[i]) begin
        if (countdown[i] == 16'd0) begin
          expected_results.push_back(make_result(KIND_DUE, 1'b0, 3'(i), 1'b0));
          n_due++;
          countdown[i] = period_tab[i] - 16'd1;
        end else begin
          countdown[i] = countdown[i] - 16'd1;
        end
      end
    end
    if (n_due == 0) begin
      expected_results.push_back(make_result(KIND_IDLE, 1'b0, 3'd0, 1'b1));
    end else begin
      expected_results[$].is_last = 1'b1;
    end
  endfunction

  function automatic void add_cmd(bit cmd, bit [7:0] slot, bit [15:0] period,
                                  bit [15:0] first_delay, bit has_handler);
    sched_cmd_t c;
    c.cmd         = cmd;
    c.slot        = slot;
    c.period      = period;
    c.first_delay = first_delay;
    c.has_handler = has_handler;
    pending_cmds.push_back(c);
  endfunction

  function automatic void add_tick();
    add_cmd(CMD_TICK, 8'($urandom), 16'($urandom), 16'($urandom), 1'($urandom));
  endfunction

  // driver: bursts of beats separated by random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        countdown[i]  = '0;
        period_tab[i] = '0;
        slot_live[i]  = 1'b0;
      end
    end else begin
      if (in_tvalid && in_tready) begin
        schedule_step(cmd_on_bus);
      end
      if (!(in_tvalid && !in_tready)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (pending_cmds.size() > 0) begin
          cmd_on_bus = pending_cmds.pop_front();
          in_tdata  <= {7'd0, cmd_on_bus.has_handler, cmd_on_bus.first_delay,
                        cmd_on_bus.period, cmd_on_bus.slot};
          in_tuser  <= cmd_on_bus.cmd;
          in_tvalid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 15);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each result beat, stall pattern changes per segment
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          $error("result beat with nothing expected: kind %0d data %h last %0d",
                 out_tuser, out_tdata, out_tlast);
          error_count++;
        end else begin
          sched_result_t e;
          e = expected_results.pop_front();
          if (out_tuser !== e.kind) begin
            $error("kind: expected %0d, got %0d", e.kind, out_tuser);
            error_count++;
          end
          if (out_tdata[0] !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, out_tdata[0]);
            error_count++;
          end
          if (out_tdata[3:1] !== e.due_slot) begin
            $error("task_res: expected %0d, got %0d", e.due_slot, out_tdata[3:1]);
            error_count++;
          end
          if (out_tlast !== e.is_last) begin
            $error("last: expected %0d, got %0d", e.is_last, out_tlast);
            error_count++;
          end
        end
      end
      if (rx_left == 0) begin
        rx_mode = $urandom_range(0, 2);
        rx_left = $urandom_range(4, 40);
      end
      rx_left--;
      case (rx_mode)
        0: begin
          out_tready <= 1'b1;
        end
        1: begin
          out_tready <= 1'($urandom);
        end
        default: begin
          out_tready <= ($urandom_range(0, 3) == 0);
        end
      endcase
    end
  end

  initial begin
    // directed part
    add_tick();                                              // empty table
    add_cmd(CMD_CREATE, 8'd8,   16'd1,     16'd0,     1'b1); // slot just out of range
    add_cmd(CMD_CREATE, 8'hFF,  16'hFFFF,  16'hFFFF,  1'b1); // slot at top of field
    add_cmd(CMD_CREATE, 8'h80,  16'h8000,  16'h8000,  1'b1);
    add_cmd(CMD_CREATE, 8'd0,   16'd1,     16'd0,     1'b0); // no handler
    for (int s = 0; s < NUM_SLOTS; s++) begin
      add_cmd(CMD_CREATE, 8'(s), 16'd1, 16'd0, 1'b1);
    end
    add_tick();                                              // every slot due
    add_cmd(CMD_CREATE, 8'd7,   16'd0,     16'd0,     1'b1); // overwrite, period zero
    add_cmd(CMD_CREATE, 8'd5,   16'hFFFF,  16'hFFFF,  1'b1);
    add_cmd(CMD_CREATE, 8'd3,   16'd4,     16'd2,     1'b0); // rejected, slot keeps running
    add_cmd(CMD_CREATE, 8'd2,   16'd3,     16'd1,     1'b1);
    add_tick();
    add_tick();
    add_tick();
    add_tick();

    // random part: mostly ticks and small-period creates, some noise creates
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 62) begin
        add_tick();
      end else if (pick < 88) begin
        add_cmd(CMD_CREATE, 8'($urandom_range(0, NUM_SLOTS - 1)),
                ($urandom_range(0, 15) == 0) ? 16'd0 : 16'($urandom_range(1, 8)),
                16'($urandom_range(0, 6)), 1'b1);
      end else begin
        add_cmd(CMD_CREATE, 8'($urandom), 16'($urandom), 16'($urandom), 1'($urandom));
      end
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_cmds.size() > 0 || in_tvalid) @(posedge clk);
    while (expected_results.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("tb_top: done, errors");
    $finish;
  end

endmodule

>>> sim.f
rtl/core/ptts_pkg.sv
rtl/core/ptts_seq.sv
rtl/core/ptts_dp.sv
rtl/core/periodic_task_tick_scheduler_core.sv
test/tb_top.sv
